// ===== rtl/touch_report_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Touch report parser assertion macros
// Shared shorthand for the concurrent checks of the touch report parser.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_PARSER_MACROS_SVH
`define TOUCH_REPORT_PARSER_MACROS_SVH

// Check on the rising edge of aclk, suspended while reset is asserted.
`define TRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on the rising edge of aclk that must also hold across reset.
`define TRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/trp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch report parser package
// Types, codes and constants shared by the touch report parser modules.
// ----------------------------------------------------------------------------
package trp_pkg;

    // Field widths of the input and result beats.
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int SECS_W     = 8;
    localparam int PIXEL_W    = 11;

    // Configuration register widths and the write port.
    localparam int SIZE_W     = 12;
    localparam int TPS_W      = 21;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 2;

    // A coordinate is two seven-bit groups.
    localparam int GROUP_W    = 7;
    localparam int RAW_W      = 2 * GROUP_W;

    // Tick limit and elapsed count hold seconds times ticks per second.
    localparam int TICK_W     = SECS_W + TPS_W;

    // Scaled product before the shift.
    localparam int PROD_W     = RAW_W + SIZE_W;

    localparam int NATIVE_BOUND_LOG2_DEFAULT = 12;

    localparam logic [BYTE_W-1:0]  HEADER_BASE = 8'h80;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX   = 11'd2047;

    // Register values after reset.
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd800;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [TPS_W-1:0]  TPS_RESET    = 21'd1000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH     = 2'd0,
        CFG_SCREEN_HEIGHT    = 2'd1,
        CFG_TICKS_PER_SECOND = 2'd2
    } cfg_index_t;

    // Input commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HEAD = 3'd1,
        PH_XLO  = 3'd2,
        PH_XHI  = 3'd3,
        PH_YLO  = 3'd4,
        PH_YHI  = 3'd5
    } phase_t;

    // One result beat.
    typedef struct packed {
        logic [PIXEL_W-1:0] x_pixel;
        logic [PIXEL_W-1:0] y_pixel;
        logic               timed_out;
    } result_t;

endpackage

// ===== rtl/trp_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch report parser result buffer
// Output register with a skid stage, so that a new beat can be taken while a
// finished result still waits on the result channel.
// ----------------------------------------------------------------------------
module trp_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  trp_pkg::result_t push_data,
    output logic             can_push,
    output logic             out_valid,
    output trp_pkg::result_t out_data,
    input  logic             out_ready
);

    logic             head_valid_reg, head_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    trp_pkg::result_t head_data_reg,  head_data_next;
    trp_pkg::result_t skid_data_reg,  skid_data_next;
    logic             pop;

    assign pop       = head_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_data_reg;

    // Move results from the input to the head, or park them in the skid stage.
    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_data_next  = head_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                head_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!head_valid_reg || pop) begin
                head_data_next  = push_data;
                head_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            head_valid_next = 1'b0;
        end
    end

    // Valid flags are cleared by reset; the data needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_data_reg <= head_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/touch_report_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch report parser
// Decodes pen reports from a received byte stream and scales them to pixels.
// ----------------------------------------------------------------------------
// The parser takes one input beat in every clock cycle while s_ready is high.
// A start beat arms a wait for a header byte of 0x80 or 0x81, and tick beats
// time that wait out on the tick that takes the count past timeout_seconds
// times ticks_per_second. The four bytes after a header give x and y, low
// seven bits first; a report with a coordinate at or above 2**NATIVE_BOUND_LOG2
// is dropped and the header wait goes on. The result of a beat is registered
// and shows on the m_ side. A two-entry result buffer sets the rate: s_ready
// falls only while two results wait unclaimed on the m_ side.
module touch_report_parser #(
    parameter int NATIVE_BOUND_LOG2 = trp_pkg::NATIVE_BOUND_LOG2_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [trp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [trp_pkg::CMD_W-1:0]       s_cmd,
    input  logic [trp_pkg::BYTE_W-1:0]      s_rx_byte,
    input  logic                            s_pen_edge,
    input  logic [trp_pkg::SECS_W-1:0]      s_timeout_seconds,
    // Result channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [trp_pkg::PIXEL_W-1:0]     m_x_pixel,
    output logic [trp_pkg::PIXEL_W-1:0]     m_y_pixel,
    output logic                            m_timed_out
);

    localparam int RAW_W   = trp_pkg::RAW_W;
    localparam int GROUP_W = trp_pkg::GROUP_W;
    localparam int TICK_W  = trp_pkg::TICK_W;
    localparam int PROD_W  = trp_pkg::PROD_W;
    localparam int PIXEL_W = trp_pkg::PIXEL_W;

    // Native coordinate bound, one bit wider than a raw coordinate.
    localparam logic [RAW_W:0] BOUND = (RAW_W+1)'(1) << NATIVE_BOUND_LOG2;
    localparam logic [TICK_W-1:0] ELAPSED_MAX = '1;

    // Configuration registers.
    logic [trp_pkg::SIZE_W-1:0] width_reg;
    logic [trp_pkg::SIZE_W-1:0] height_reg;
    logic [trp_pkg::TPS_W-1:0]  tps_reg;

    // Decoder state.
    trp_pkg::phase_t   phase_reg,   phase_next;
    logic              edge_reg,    edge_next;
    logic [TICK_W-1:0] limit_reg,   limit_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [RAW_W-1:0]  raw_x_reg,   raw_x_next;
    logic [RAW_W-1:0]  raw_y_reg,   raw_y_next;

    logic              accept;
    logic              push;
    trp_pkg::result_t  push_data;
    trp_pkg::result_t  out_data;
    logic [GROUP_W-1:0] seven;
    logic [RAW_W-1:0]  y_full;
    logic              in_bounds;
    logic [PROD_W-1:0] prod_x, prod_y;
    logic [PROD_W-1:0] shift_x, shift_y;
    logic [TICK_W-1:0] elapsed_inc;

    assign accept = s_valid && s_ready;
    assign seven  = s_rx_byte[GROUP_W-1:0];

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= trp_pkg::WIDTH_RESET;
            height_reg <= trp_pkg::HEIGHT_RESET;
            tps_reg    <= trp_pkg::TPS_RESET;
        end else if (cfg_wr_en) begin
            case (trp_pkg::cfg_index_t'(cfg_index))
                trp_pkg::CFG_SCREEN_WIDTH:     width_reg  <= cfg_wdata[trp_pkg::SIZE_W-1:0];
                trp_pkg::CFG_SCREEN_HEIGHT:    height_reg <= cfg_wdata[trp_pkg::SIZE_W-1:0];
                trp_pkg::CFG_TICKS_PER_SECOND: tps_reg    <= cfg_wdata[trp_pkg::TPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Bounds check and scaling of a completed report.
    assign y_full    = {seven, raw_y_reg[GROUP_W-1:0]};
    assign in_bounds = ({1'b0, raw_x_reg} < BOUND) && ({1'b0, y_full} < BOUND);
    assign prod_x    = PROD_W'(raw_x_reg) * PROD_W'(width_reg);
    assign prod_y    = PROD_W'(y_full) * PROD_W'(height_reg);
    assign shift_x   = prod_x >> NATIVE_BOUND_LOG2;
    assign shift_y   = prod_y >> NATIVE_BOUND_LOG2;

    // Saturating tick count.
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + TICK_W'(1);

    // Next state and result for the accepted beat.
    always_comb begin
        phase_next   = phase_reg;
        edge_next    = edge_reg;
        limit_next   = limit_reg;
        elapsed_next = elapsed_reg;
        raw_x_next   = raw_x_reg;
        raw_y_next   = raw_y_reg;
        push         = 1'b0;
        push_data    = '0;
        if (accept) begin
            if (s_cmd == trp_pkg::CMD_START) begin
                edge_next    = s_pen_edge;
                limit_next   = TICK_W'(s_timeout_seconds) * TICK_W'(tps_reg);
                elapsed_next = '0;
                raw_x_next   = '0;
                raw_y_next   = '0;
                phase_next   = trp_pkg::PH_HEAD;
            end else if (phase_reg != trp_pkg::PH_IDLE && s_cmd == trp_pkg::CMD_TICK) begin
                elapsed_next = elapsed_inc;
                if (phase_reg == trp_pkg::PH_HEAD && elapsed_inc > limit_reg) begin
                    phase_next          = trp_pkg::PH_IDLE;
                    push                = 1'b1;
                    push_data.timed_out = 1'b1;
                end
            end else if (phase_reg != trp_pkg::PH_IDLE && s_cmd == trp_pkg::CMD_BYTE) begin
                case (phase_reg)
                    trp_pkg::PH_HEAD: begin
                        if (s_rx_byte == (trp_pkg::HEADER_BASE | trp_pkg::BYTE_W'(edge_reg))) begin
                            phase_next = trp_pkg::PH_XLO;
                        end
                    end
                    trp_pkg::PH_XLO: begin
                        raw_x_next = RAW_W'(seven);
                        phase_next = trp_pkg::PH_XHI;
                    end
                    trp_pkg::PH_XHI: begin
                        raw_x_next = {seven, raw_x_reg[GROUP_W-1:0]};
                        phase_next = trp_pkg::PH_YLO;
                    end
                    trp_pkg::PH_YLO: begin
                        raw_y_next = RAW_W'(seven);
                        phase_next = trp_pkg::PH_YHI;
                    end
                    trp_pkg::PH_YHI: begin
                        raw_y_next = y_full;
                        if (!in_bounds) begin
                            phase_next = trp_pkg::PH_HEAD;
                        end else begin
                            phase_next        = trp_pkg::PH_IDLE;
                            push              = 1'b1;
                            push_data.x_pixel = (shift_x[PROD_W-1:PIXEL_W] != '0)
                                                ? trp_pkg::PIXEL_MAX : shift_x[PIXEL_W-1:0];
                            push_data.y_pixel = (shift_y[PROD_W-1:PIXEL_W] != '0)
                                                ? trp_pkg::PIXEL_MAX : shift_y[PIXEL_W-1:0];
                        end
                    end
                    default: begin
                        phase_next = trp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Decoder state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= trp_pkg::PH_IDLE;
            edge_reg    <= 1'b0;
            limit_reg   <= '0;
            elapsed_reg <= '0;
            raw_x_reg   <= '0;
            raw_y_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            edge_reg    <= edge_next;
            limit_reg   <= limit_next;
            elapsed_reg <= elapsed_next;
            raw_x_reg   <= raw_x_next;
            raw_y_reg   <= raw_y_next;
        end
    end

    // Result register with skid stage.
    trp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .can_push  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    assign m_x_pixel   = out_data.x_pixel;
    assign m_y_pixel   = out_data.y_pixel;
    assign m_timed_out = out_data.timed_out;

endmodule

// ===== rtl/trp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch report parser checker
// Port-level checks of the touch report parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_report_parser_macros.svh"

module trp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [trp_pkg::PIXEL_W-1:0]     m_x_pixel,
    input logic [trp_pkg::PIXEL_W-1:0]     m_y_pixel,
    input logic                            m_timed_out
);

    logic                          stall;
    logic                          beat_in;
    logic                          timeout_shown;
    logic                          coords_zero;
    logic [2*trp_pkg::PIXEL_W:0]   result_bits;

    // Shorthand for the handshake and the result payload.
    assign stall         = m_valid && !m_ready;
    assign beat_in       = s_valid && s_ready;
    assign timeout_shown = m_valid && m_timed_out;
    assign coords_zero   = (m_x_pixel == '0) && (m_y_pixel == '0);
    assign result_bits   = {m_x_pixel, m_y_pixel, m_timed_out};

    // A stalled result beat holds its payload.
    `TRP_ASSERT(a_result_held, stall |=> m_valid && $stable(result_bits), "Stalled result changed")

    // A timeout carries zero coordinates.
    `TRP_ASSERT(a_timeout_zero, timeout_shown |-> coords_zero, "Timeout with non-zero coordinates")

    // A new result only follows an accepted input beat.
    `TRP_ASSERT(a_result_cause, $rose(m_valid) |-> $past(beat_in), "Result without an input beat")

    // Reset leaves the result channel empty.
    `TRP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "Result valid after reset")

endmodule

bind touch_report_parser trp_checker u_trp_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch report parser testbench
// Drives start, byte and tick beats into the parser and checks every result
// beat against a cycle-free predictor of the decoder. A short scripted run
// covers the corner cases under the reset settings; randomised pen sessions
// follow under eight register settings and four flow-control patterns.
// ----------------------------------------------------------------------------
module tb;
    import trp_pkg::*;

    localparam int BOUND_LOG2 = NATIVE_BOUND_LOG2_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [31:0] ELAPSED_SAT = 32'h1FFF_FFFF;
    localparam int N_SETTINGS = 8;
    localparam int BEATS_PER_SETTING = 88;
    localparam int MAX_PRINTED = 50;

    // One input beat.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] rx_byte;
        logic              pen_edge;
        logic [SECS_W-1:0] secs;
    } beat_t;

    // One row of the scripted run; the result is typed in where obvious.
    typedef struct {
        beat_t   beat;
        bit      typed;
        bit      has_result;
        result_t want;
    } script_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd = '0;
    logic [BYTE_W-1:0]     s_rx_byte = '0;
    logic                  s_pen_edge = 1'b0;
    logic [SECS_W-1:0]     s_timeout_seconds = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIXEL_W-1:0]    m_x_pixel;
    logic [PIXEL_W-1:0]    m_y_pixel;
    logic                  m_timed_out;

    touch_report_parser dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_rx_byte         (s_rx_byte),
        .s_pen_edge        (s_pen_edge),
        .s_timeout_seconds (s_timeout_seconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_x_pixel         (m_x_pixel),
        .m_y_pixel         (m_y_pixel),
        .m_timed_out       (m_timed_out)
    );

    // Predictor copy of the registers and the decoder state.
    logic [SIZE_W-1:0] width_q  = WIDTH_RESET;
    logic [SIZE_W-1:0] height_q = HEIGHT_RESET;
    logic [TPS_W-1:0]  tps_q    = TPS_RESET;
    phase_t            phase_q  = PH_IDLE;
    logic              edge_q   = 1'b0;
    logic [31:0]       limit_q  = '0;
    logic [31:0]       elapsed_q = '0;
    logic [RAW_W-1:0]  raw_x_q  = '0;
    logic [RAW_W-1:0]  raw_y_q  = '0;

    result_t     pending_results[$];
    script_row_t script[$];

    int n_errors   = 0;
    int n_beats    = 0;
    int n_reports  = 0;
    int n_timeouts = 0;
    int n_drops    = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic report_mismatch(input string what);
        if (n_errors < MAX_PRINTED)
            $display("tb: mismatch at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    // Raw coordinate scaled to pixels, clamped to the output range.
    function automatic logic [PIXEL_W-1:0] to_pixels(input logic [RAW_W-1:0] raw,
                                                      input logic [SIZE_W-1:0] size);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * PROD_W'(size);
        prod = prod >> BOUND_LOG2;
        return (prod > PIXEL_MAX) ? PIXEL_MAX : prod[PIXEL_W-1:0];
    endfunction

    // Advances the predicted decoder by one beat; returns 1 with a result.
    function automatic bit decode_beat(input beat_t b, output result_t r);
        logic [GROUP_W-1:0] seven;
        seven = b.rx_byte[GROUP_W-1:0];
        r = '0;
        if (b.cmd == CMD_START) begin
            edge_q    = b.pen_edge;
            limit_q   = 32'(b.secs) * 32'(tps_q);
            elapsed_q = '0;
            raw_x_q   = '0;
            raw_y_q   = '0;
            phase_q   = PH_HEAD;
            return 1'b0;
        end
        if (phase_q == PH_IDLE || b.cmd == CMD_UNUSED)
            return 1'b0;

        // Ticks count in every busy phase but only time out the header wait.
        if (b.cmd == CMD_TICK) begin
            if (elapsed_q < ELAPSED_SAT)
                elapsed_q++;
            if (phase_q == PH_HEAD && elapsed_q > limit_q) begin
                phase_q = PH_IDLE;
                r.timed_out = 1'b1;
                n_timeouts++;
                return 1'b1;
            end
            return 1'b0;
        end

        case (phase_q)
            PH_HEAD: begin
                if (b.rx_byte == (HEADER_BASE | {7'd0, edge_q}))
                    phase_q = PH_XLO;
            end
            PH_XLO: begin
                raw_x_q = {7'd0, seven};
                phase_q = PH_XHI;
            end
            PH_XHI: begin
                raw_x_q = {seven, raw_x_q[GROUP_W-1:0]};
                phase_q = PH_YLO;
            end
            PH_YLO: begin
                raw_y_q = {7'd0, seven};
                phase_q = PH_YHI;
            end
            PH_YHI: begin
                raw_y_q = {seven, raw_y_q[GROUP_W-1:0]};
                if (int'(raw_x_q) >= (1 << BOUND_LOG2) ||
                    int'(raw_y_q) >= (1 << BOUND_LOG2)) begin
                    phase_q = PH_HEAD;
                    n_drops++;
                    return 1'b0;
                end
                phase_q = PH_IDLE;
                r.x_pixel = to_pixels(raw_x_q, width_q);
                r.y_pixel = to_pixels(raw_y_q, height_q);
                n_reports++;
                return 1'b1;
            end
            default: phase_q = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    // Offers one beat, waits for it to be taken and records what it should give.
    task automatic send_beat(input beat_t b, input bit typed, input bit has_result,
                             input result_t want);
        result_t predicted;
        bit      gives;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid           = 1'b1;
        s_cmd             = b.cmd;
        s_rx_byte         = b.rx_byte;
        s_pen_edge        = b.pen_edge;
        s_timeout_seconds = b.secs;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (b.cmd == CMD_START || (phase_q != PH_IDLE && b.cmd != CMD_UNUSED))
            n_beats++;
        gives = decode_beat(b, predicted);
        if (typed) begin
            if (has_result)
                pending_results.push_back(want);
        end else if (gives) begin
            pending_results.push_back(predicted);
        end
        @(negedge aclk);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] rx,
                           input logic pen, input logic [SECS_W-1:0] secs,
                           input int typed, input int has_result,
                           input int x, input int y, input int timed_out);
        script_row_t row;
        row.beat.cmd        = cmd;
        row.beat.rx_byte    = rx;
        row.beat.pen_edge   = pen;
        row.beat.secs       = secs;
        row.typed           = (typed != 0);
        row.has_result      = (has_result != 0);
        row.want.x_pixel    = PIXEL_W'(x);
        row.want.y_pixel    = PIXEL_W'(y);
        row.want.timed_out  = (timed_out != 0);
        script.push_back(row);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:     width_q  = data[SIZE_W-1:0];
            CFG_SCREEN_HEIGHT:    height_q = data[SIZE_W-1:0];
            CFG_TICKS_PER_SECOND: tps_q    = data[TPS_W-1:0];
            default: ;
        endcase
    endtask

    // Lets all results drain and the pipeline settle.
    task automatic drain;
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // One pen session: a start, then mostly well-formed traffic until the
    // wait ends or the session runs long.
    task automatic run_session;
        beat_t b;
        int    steps;
        int    pick;
        b.cmd      = CMD_START;
        b.rx_byte  = 8'($urandom);
        b.pen_edge = 1'($urandom);
        b.secs     = ($urandom_range(99) < 60) ? 8'($urandom_range(3)) : 8'($urandom);
        send_beat(b, 1'b0, 1'b0, '0);
        steps = 0;
        while (phase_q != PH_IDLE && steps < 40) begin
            steps++;
            pick       = $urandom_range(99);
            b.cmd      = 2'($urandom_range(3));
            b.rx_byte  = 8'($urandom);
            b.pen_edge = 1'($urandom);
            b.secs     = 8'($urandom);
            if (phase_q == PH_HEAD) begin
                if (pick < 45) begin
                    b.cmd     = CMD_BYTE;
                    b.rx_byte = HEADER_BASE | {7'd0, edge_q};
                end else if (pick < 60) begin
                    b.cmd = CMD_BYTE;
                end else if (pick < 90) begin
                    b.cmd = CMD_TICK;
                end else if (pick < 95) begin
                    b.cmd = CMD_UNUSED;
                end else begin
                    b.cmd  = CMD_START;
                    b.secs = 8'($urandom_range(3));
                end
            end else begin
                // Payload: high groups are mostly kept inside the native bound.
                if (pick < 80) begin
                    b.cmd = CMD_BYTE;
                    if ((phase_q == PH_XHI || phase_q == PH_YHI) &&
                        $urandom_range(4) != 0)
                        b.rx_byte[6:5] = 2'b00;
                end else if (pick < 95) begin
                    b.cmd = CMD_TICK;
                end else begin
                    b.cmd = CMD_UNUSED;
                end
            end
            send_beat(b, 1'b0, 1'b0, '0);
        end
        // Now and then a stray beat after the session.
        if ($urandom_range(7) == 0) begin
            b.cmd     = 2'($urandom_range(1, 3));
            b.rx_byte = 8'($urandom);
            send_beat(b, 1'b0, 1'b0, '0);
        end
    endtask

    // Result checker: each result beat against the oldest expectation.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result x %0d y %0d timed_out %0b",
                                          m_x_pixel, m_y_pixel, m_timed_out));
            end else begin
                want = pending_results.pop_front();
                if (m_x_pixel !== want.x_pixel)
                    report_mismatch($sformatf("x_pixel %0d, expected %0d",
                                              m_x_pixel, want.x_pixel));
                if (m_y_pixel !== want.y_pixel)
                    report_mismatch($sformatf("y_pixel %0d, expected %0d",
                                              m_y_pixel, want.y_pixel));
                if (m_timed_out !== want.timed_out)
                    report_mismatch($sformatf("timed_out %0b, expected %0b",
                                              m_timed_out, want.timed_out));
            end
        end
    end

    // Main sequence.
    initial begin
        logic [SIZE_W-1:0]     w_set [N_SETTINGS];
        logic [SIZE_W-1:0]     h_set [N_SETTINGS];
        logic [CFG_DATA_W-1:0] tps_set [N_SETTINGS];
        int                    stop_at;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Scripted corner cases under the reset register values.
        add_row(CMD_BYTE,   8'h81, 1'b0, 8'd0,   1, 0, 0, 0, 0);    // byte while idle
        add_row(CMD_TICK,   8'h00, 1'b0, 8'd0,   1, 0, 0, 0, 0);    // tick while idle
        add_row(CMD_UNUSED, 8'hFF, 1'b1, 8'hFF,  1, 0, 0, 0, 0);    // unused code
        add_row(CMD_START,  8'h00, 1'b1, 8'd0,   0, 0, 0, 0, 0);    // zero timeout
        add_row(CMD_TICK,   8'h00, 1'b0, 8'd0,   1, 1, 0, 0, 1);
        add_row(CMD_START,  8'h00, 1'b1, 8'd5,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'h80, 1'b0, 8'd0,   0, 0, 0, 0, 0);    // wrong header
        add_row(CMD_BYTE,   8'h81, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'hFF, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'hFF, 1'b0, 8'd0,   0, 0, 0, 0, 0);    // x out of bound
        add_row(CMD_BYTE,   8'h00, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'h00, 1'b0, 8'd0,   0, 0, 0, 0, 0);    // report dropped
        add_row(CMD_START,  8'h00, 1'b1, 8'd1,   0, 0, 0, 0, 0);    // restart while busy
        add_row(CMD_BYTE,   8'h81, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'hFF, 1'b0, 8'd0,   0, 0, 0, 0, 0);    // bit 7 ignored
        add_row(CMD_BYTE,   8'h9F, 1'b0, 8'd0,   0, 0, 0, 0, 0);    // x = 4095
        add_row(CMD_UNUSED, 8'h00, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'h80, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'h80, 1'b0, 8'd0,   1, 1, 799, 0, 0);
        add_row(CMD_START,  8'h00, 1'b0, 8'd255, 0, 0, 0, 0, 0);    // pen up
        add_row(CMD_BYTE,   8'h80, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_TICK,   8'h00, 1'b0, 8'd0,   0, 0, 0, 0, 0);    // tick in payload
        add_row(CMD_BYTE,   8'h00, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'h00, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'h7F, 1'b0, 8'd0,   0, 0, 0, 0, 0);
        add_row(CMD_BYTE,   8'h1F, 1'b0, 8'd0,   1, 1, 0, 479, 0);  // y = 4095
        foreach (script[i])
            send_beat(script[i].beat, script[i].typed, script[i].has_result, script[i].want);

        // Register settings, the extremes among them.
        w_set   = '{12'd800, 12'd1, 12'd2048, 12'd4095, 12'd2047,
                    12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)), WIDTH_RESET};
        h_set   = '{12'd480, 12'd1, 12'd2048, 12'd4095, 12'd1,
                    12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)), HEIGHT_RESET};
        tps_set = '{21'd2, 21'd1, 21'd3, 21'd1, 21'h1FFFFF,
                    21'd1048576, 21'($urandom_range(1, 4)), 21'(TPS_RESET)};

        for (int p = 0; p < N_SETTINGS; p++) begin
            drain();
            write_register(CFG_SCREEN_WIDTH, CFG_DATA_W'(w_set[p]));
            write_register(CFG_SCREEN_HEIGHT, CFG_DATA_W'(h_set[p]));
            write_register(CFG_TICKS_PER_SECOND, tps_set[p]);
            write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
                default: begin src_idle_pct = 20; snk_stall_pct = 20; end
            endcase
            stop_at = n_beats + BEATS_PER_SETTING;
            while (n_beats < stop_at)
                run_session();
        end

        drain();
        repeat (10) @(negedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        $display("Run covered %0d beats: %0d reports, %0d timeouts, %0d dropped reports.",
                 n_beats, n_reports, n_timeouts, n_drops);
        $display("Register settings: %0d, flow patterns: 4, mismatches: %0d.",
                 N_SETTINGS, n_errors);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
